// ----- design/trf_pkg.sv -----
// shared types and constants for the tape record framer
`timescale 1ns / 1ps

package trf_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h2A;
    localparam logic [7:0] TAIL_BYTE   = 8'h2F;
    localparam logic [7:0] END_BYTE    = 8'h04;

    localparam int unsigned LEN_W = 17;
    localparam logic [LEN_W-1:0] LEN_MAX = 17'h10000;
    localparam logic [LEN_W-1:0] LEN_MIN = 17'h00001;

    // configuration register indexes
    localparam logic [1:0] REG_LOAD_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_TAPE_ID       = 2'd1;
    localparam logic [1:0] REG_RECORD_LENGTH = 2'd2;

    // positions within the bytes caused by one item
    localparam logic [3:0] POS_HEADER   = 4'd0;
    localparam logic [3:0] POS_TAPE_ID  = 4'd1;
    localparam logic [3:0] POS_START_LO = 4'd2;
    localparam logic [3:0] POS_START_HI = 4'd3;
    localparam logic [3:0] POS_END_LO   = 4'd4;
    localparam logic [3:0] POS_END_HI   = 4'd5;
    localparam logic [3:0] POS_DATA     = 4'd6;
    localparam logic [3:0] POS_TAIL     = 4'd7;
    localparam logic [3:0] POS_SUM_LO   = 4'd8;
    localparam logic [3:0] POS_SUM_HI   = 4'd9;
    localparam logic [3:0] POS_END_A    = 4'd10;
    localparam logic [3:0] POS_END_B    = 4'd11;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        open;
        logic        close;
        logic [7:0]  tape_id;
        logic [15:0] start_addr;
        logic [15:0] end_addr;
        logic [15:0] checksum;
    } trf_entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        trf_entry_t entry;
    } trf_head_t;

endpackage

// ----- design/tape_record_framer.sv -----
// Tape record framer: wraps each group of record_length payload bytes in a tape record
// with a six-byte header (0x2A, tape id, start and end address) and a five-byte trailer
// (0x2F, 16-bit additive checksum, 0x04 twice). The front end takes one payload byte
// per cycle unless the queue is full, tracks record position and checksum, and queues
// a classified item; the back end emits one output byte per cycle from that queue
// unless out_stall is high. A middle byte yields just its data byte, an opening one
// adds the header and a closing one the trailer, so the sustained rate is one item per
// cycle inside a record if unstalled; the output sets the pace at record boundaries,
// with QUEUE_DEPTH items of slack. Registers are read live: the header takes
// the values present when the record opens. There is no clearing pass after reset.
`timescale 1ns / 1ps

module tape_record_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        record_end
);

    trf_pkg::trf_entry_t push_entry;
    trf_pkg::trf_head_t  head;
    logic                push;
    logic                pop;
    logic                queue_full;

    trf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    trf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    trf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .record_end (record_end)
    );

endmodule

// ----- design/trf_front.sv -----
// front end: configuration registers, record position and checksum tracking
`timescale 1ns / 1ps

module trf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                queue_full,
    output logic                push,
    output trf_pkg::trf_entry_t push_entry
);

    logic [15:0] load_address_reg, load_address_next;
    logic [7:0]  tape_id_reg, tape_id_next;
    logic [16:0] record_length_reg, record_length_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] running_sum_reg, running_sum_next;

    logic [16:0] eff_len;
    logic [15:0] len_minus_one;
    logic [15:0] end_addr;
    logic [15:0] addr_sum;
    logic [15:0] base_sum;
    logic [15:0] sum_now;
    logic        open_rec;
    logic        close_rec;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_stall  = queue_full;
    assign push      = in_valid & ~queue_full;

    always_comb
    begin
        if (record_length_reg == 17'd0)
        begin
            eff_len = trf_pkg::LEN_MIN;
        end
        else if (record_length_reg > trf_pkg::LEN_MAX)
        begin
            eff_len = trf_pkg::LEN_MAX;
        end
        else
        begin
            eff_len = record_length_reg;
        end
    end

    assign len_minus_one = 16'(eff_len - 17'd1);
    assign end_addr      = load_address_reg + len_minus_one;
    assign addr_sum      = {8'd0, load_address_reg[7:0]} + {8'd0, load_address_reg[15:8]}
                         + {8'd0, end_addr[7:0]} + {8'd0, end_addr[15:8]};
    assign open_rec      = (byte_position_reg == 16'd0);
    assign base_sum      = open_rec ? addr_sum : running_sum_reg;
    assign sum_now       = base_sum + {8'd0, data_byte};
    assign close_rec     = ({1'b0, byte_position_reg} + 17'd1) >= eff_len;

    always_comb
    begin
        push_entry.data       = data_byte;
        push_entry.open       = open_rec;
        push_entry.close      = close_rec;
        push_entry.tape_id    = tape_id_reg;
        push_entry.start_addr = load_address_reg;
        push_entry.end_addr   = end_addr;
        push_entry.checksum   = sum_now;
    end

    always_comb
    begin
        load_address_next  = load_address_reg;
        tape_id_next       = tape_id_reg;
        record_length_next = record_length_reg;
        byte_position_next = byte_position_reg;
        running_sum_next   = running_sum_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                trf_pkg::REG_LOAD_ADDRESS:  load_address_next  = cfg_data[15:0];
                trf_pkg::REG_TAPE_ID:       tape_id_next       = cfg_data[7:0];
                trf_pkg::REG_RECORD_LENGTH: record_length_next = cfg_data;
                default:                    ;
            endcase
        end
        if (push)
        begin
            if (close_rec)
            begin
                byte_position_next = 16'd0;
                running_sum_next   = 16'd0;
            end
            else
            begin
                byte_position_next = byte_position_reg + 16'd1;
                running_sum_next   = sum_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_address_reg  <= 16'd0;
            tape_id_reg       <= 8'd1;
            record_length_reg <= 17'd1;
            byte_position_reg <= 16'd0;
            running_sum_reg   <= 16'd0;
        end
        else
        begin
            load_address_reg  <= load_address_next;
            tape_id_reg       <= tape_id_next;
            record_length_reg <= record_length_next;
            byte_position_reg <= byte_position_next;
            running_sum_reg   <= running_sum_next;
        end
    end

endmodule

// ----- design/trf_queue.sv -----
// short first-word-fall-through queue between front and back end
`timescale 1ns / 1ps

module trf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  trf_pkg::trf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output trf_pkg::trf_head_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    trf_pkg::trf_entry_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = store[rd_ptr_reg];
    assign do_pop     = pop & head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/trf_back.sv -----
// back end: walks the bytes of each queued item into the output register
`timescale 1ns / 1ps

module trf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  trf_pkg::trf_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               record_end
);

    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       record_end_reg;

    logic [3:0] cur;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       advance;
    logic       fire;

    // an item that opens no record starts at its data byte
    assign cur = (step_reg == trf_pkg::POS_HEADER && !head.entry.open)
               ? trf_pkg::POS_DATA : step_reg;

    assign cur_last = (cur == trf_pkg::POS_DATA && !head.entry.close)
                    || (cur == trf_pkg::POS_END_B);

    always_comb
    begin
        case (cur)
            trf_pkg::POS_HEADER:   cur_byte = trf_pkg::HEADER_BYTE;
            trf_pkg::POS_TAPE_ID:  cur_byte = head.entry.tape_id;
            trf_pkg::POS_START_LO: cur_byte = head.entry.start_addr[7:0];
            trf_pkg::POS_START_HI: cur_byte = head.entry.start_addr[15:8];
            trf_pkg::POS_END_LO:   cur_byte = head.entry.end_addr[7:0];
            trf_pkg::POS_END_HI:   cur_byte = head.entry.end_addr[15:8];
            trf_pkg::POS_DATA:     cur_byte = head.entry.data;
            trf_pkg::POS_TAIL:     cur_byte = trf_pkg::TAIL_BYTE;
            trf_pkg::POS_SUM_LO:   cur_byte = head.entry.checksum[7:0];
            trf_pkg::POS_SUM_HI:   cur_byte = head.entry.checksum[15:8];
            trf_pkg::POS_END_A:    cur_byte = trf_pkg::END_BYTE;
            trf_pkg::POS_END_B:    cur_byte = trf_pkg::END_BYTE;
            default:               cur_byte = trf_pkg::END_BYTE;
        endcase
    end

    assign advance = ~out_valid_reg | ~out_stall;
    assign fire    = advance & head.valid;
    assign pop     = fire & cur_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            step_next      = cur_last ? trf_pkg::POS_HEADER : cur + 4'd1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg   <= cur_byte;
            run_last_reg   <= cur_last;
            record_end_reg <= (cur == trf_pkg::POS_END_B);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= trf_pkg::POS_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign record_end = record_end_reg;

endmodule

// ----- tb/tb_tape_record_framer.sv -----
// self-checking testbench for the tape record framer
`timescale 1ns / 1ps

module tb_tape_record_framer;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 40;
    localparam int RANDOM_ITEMS = 480;
    localparam int WRAP_LENGTH  = 280;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       rec_end;
    } framed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = trf_pkg::REG_LOAD_ADDRESS;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        record_end;

    // copy of the block's registers and record state
    logic [15:0] cur_load_addr = 16'h0000;
    logic [7:0]  cur_tape_id = 8'h01;
    logic [16:0] cur_rec_len = trf_pkg::LEN_MIN;
    int unsigned rec_pos = 0;
    logic [15:0] rec_sum = 16'h0000;

    framed_byte_t framed_q[$];

    int accept_count = 0;
    int cfg_count = 0;
    int result_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit tx_burst = 1'b0;
    int stall_left = 0;
    int free_left = 0;

    tape_record_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .record_end (record_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     result_count, what, got, want);
    endtask

    // expected framed bytes for one payload byte
    task automatic frame_payload_byte(input logic [7:0] data);
        framed_byte_t burst[12];
        int           k;
        int unsigned  len;
        logic [15:0]  start_a;
        logic [15:0]  end_a;
        k = 0;
        if (cur_rec_len == 17'd0)
            len = 1;
        else if (cur_rec_len > trf_pkg::LEN_MAX)
            len = 32'(trf_pkg::LEN_MAX);
        else
            len = 32'(cur_rec_len);
        if (rec_pos == 0)
        begin
            start_a = cur_load_addr;
            end_a = start_a + 16'(len - 1);
            burst[k++] = '{trf_pkg::HEADER_BYTE, 1'b0, 1'b0};
            burst[k++] = '{cur_tape_id, 1'b0, 1'b0};
            burst[k++] = '{start_a[7:0], 1'b0, 1'b0};
            burst[k++] = '{start_a[15:8], 1'b0, 1'b0};
            burst[k++] = '{end_a[7:0], 1'b0, 1'b0};
            burst[k++] = '{end_a[15:8], 1'b0, 1'b0};
            rec_sum = 16'(start_a[7:0]) + 16'(start_a[15:8])
                    + 16'(end_a[7:0]) + 16'(end_a[15:8]);
        end
        burst[k++] = '{data, 1'b0, 1'b0};
        rec_sum = rec_sum + 16'(data);
        if (rec_pos + 1 >= len)
        begin
            burst[k++] = '{trf_pkg::TAIL_BYTE, 1'b0, 1'b0};
            burst[k++] = '{rec_sum[7:0], 1'b0, 1'b0};
            burst[k++] = '{rec_sum[15:8], 1'b0, 1'b0};
            burst[k++] = '{trf_pkg::END_BYTE, 1'b0, 1'b0};
            burst[k++] = '{trf_pkg::END_BYTE, 1'b0, 1'b1};
            rec_pos = 0;
            rec_sum = 16'h0000;
        end
        else
            rec_pos = rec_pos + 1;
        burst[k-1].last = 1'b1;
        for (int i = 0; i < k; i++)
            framed_q.push_back(burst[i]);
    endtask

    // register writes, accepted items and results, all sampled at the rising edge
    always @(posedge clk)
    begin
        framed_byte_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    trf_pkg::REG_LOAD_ADDRESS:  cur_load_addr = cfg_data[15:0];
                    trf_pkg::REG_TAPE_ID:       cur_tape_id = cfg_data[7:0];
                    trf_pkg::REG_RECORD_LENGTH: cur_rec_len = cfg_data;
                    default: ;
                endcase
                cfg_count++;
            end
            if (in_valid && !in_stall)
            begin
                frame_payload_byte(data_byte);
                accept_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (framed_q.size() == 0)
                    report_mismatch("unexpected result, out_byte", out_byte, 0);
                else
                begin
                    want = framed_q.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch("out_byte", out_byte, want.value);
                    if (run_last !== want.last)
                        report_mismatch("run_last", run_last, want.last);
                    if (record_end !== want.rec_end)
                        report_mismatch("record_end", record_end, want.rec_end);
                end
                result_count++;
            end
        end
    end

    // receiver stalls: mostly short, a few long, with calm stretches
    always @(negedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            r = $urandom_range(0, 99);
            free_left = (r < 15) ? $urandom_range(20, 60) : $urandom_range(0, 4);
            r = $urandom_range(0, 99);
            if (r < 30)
                stall_left = 0;
            else if (r < 85)
                stall_left = $urandom_range(1, 3);
            else if (r < 96)
                stall_left = $urandom_range(4, 12);
            else
                stall_left = $urandom_range(20, 50);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at a falling edge once the write is taken and cfg_valid dropped
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        int target;
        target = cfg_count + 1;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (cfg_count < target)
            @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] value);
        int gap;
        int target;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        target = accept_count + 1;
        data_byte <= value;
        in_valid <= 1'b1;
        @(negedge clk);
        while (accept_count < target)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (framed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_defaults_after_reset();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        wait_idle();
    endtask

    task automatic test_header_extremes();
        // end address wraps past 0xffff
        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h0FFFF);
        write_reg(trf_pkg::REG_TAPE_ID, 17'd254);
        write_reg(trf_pkg::REG_RECORD_LENGTH, 17'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_idle();
        // tape ids outside the usual range go out unchanged
        write_reg(trf_pkg::REG_TAPE_ID, 17'd0);
        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h01234);
        write_reg(trf_pkg::REG_RECORD_LENGTH, 17'd3);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        wait_idle();
        write_reg(trf_pkg::REG_TAPE_ID, 17'h1FFFF);
        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h00000);
        // leaves the record open
        send_byte(8'h55);
        send_byte(8'hAA);
        wait_idle();
    endtask

    task automatic test_length_limits();
        // zero length acts as one and closes the open record
        write_reg(trf_pkg::REG_RECORD_LENGTH, 17'd0);
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_idle();
        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h08000);
        write_reg(trf_pkg::REG_RECORD_LENGTH, 17'h1FFFF);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        write_reg(trf_pkg::REG_RECORD_LENGTH, trf_pkg::LEN_MAX);
        send_byte(8'h44);
        wait_idle();
        // shrinking mid-record closes on the next item
        write_reg(trf_pkg::REG_RECORD_LENGTH, 17'd2);
        send_byte(8'h66);
        wait_idle();
    endtask

    task automatic test_unknown_index();
        write_reg(REG_UNUSED, 17'h1FFFF);
        write_reg(REG_UNUSED, 17'h00000);
        send_byte(8'h5A);
        send_byte(8'hA5);
        wait_idle();
    endtask

    task automatic test_random_records();
        int          sent;
        int          count;
        int          r;
        bit          wrap_done;
        bit          high_data;
        logic [16:0] len;
        logic [7:0]  value;
        sent = 0;
        wrap_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            high_data = 1'b0;
            if (!wrap_done && sent > RANDOM_ITEMS / 2)
            begin
                // close whatever is open, then one long record of high bytes
                // so that the checksum wraps
                write_reg(trf_pkg::REG_RECORD_LENGTH, 17'd1);
                send_byte(pick_data());
                wait_idle();
                write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h0FFFF);
                len = 17'(WRAP_LENGTH);
                count = WRAP_LENGTH;
                high_data = 1'b1;
                wrap_done = 1'b1;
                sent++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = 17'($urandom_range(1, 6));
                else if (r < 85)
                    len = 17'($urandom_range(7, 40));
                else if (r < 92)
                    len = 17'd0;
                else if (r < 96)
                    len = 17'($urandom_range(65537, 131071));
                else
                    len = trf_pkg::LEN_MAX;
                count = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h00000);
                    else if (r < 30)
                        write_reg(trf_pkg::REG_LOAD_ADDRESS, 17'h0FFFF);
                    else
                        write_reg(trf_pkg::REG_LOAD_ADDRESS,
                                  17'($urandom_range(0, 65535)));
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        write_reg(trf_pkg::REG_TAPE_ID, 17'd0);
                    else if (r < 16)
                        write_reg(trf_pkg::REG_TAPE_ID, 17'd255);
                    else
                        write_reg(trf_pkg::REG_TAPE_ID, 17'($urandom_range(1, 254)));
                end
                if ($urandom_range(0, 9) == 0)
                    write_reg(REG_UNUSED, 17'($urandom_range(0, 131071)));
            end
            write_reg(trf_pkg::REG_RECORD_LENGTH, len);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < count; i++)
            begin
                value = high_data ? 8'($urandom_range(240, 255)) : pick_data();
                send_byte(value);
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
            sent += count;
            wait_idle();
        end
        tx_burst = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_defaults_after_reset();
        test_header_extremes();
        test_length_limits();
        test_unknown_index();
        test_random_records();
        wait_idle();
        if (mismatch_count == 0 && framed_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/trf_pkg.sv
design/trf_front.sv
design/trf_queue.sv
design/trf_back.sv
design/tape_record_framer.sv
tb/tb_tape_record_framer.sv
